// ===== hdl/spu_pkg.sv =====
`timescale 1ns / 1ps

package spu_pkg;

    localparam int GroupW   = 56;
    localparam int ByteW    = 8;
    localparam int SeptW    = 7;
    localparam int IdxW     = 3;
    localparam int ShiftW   = 6;
    localparam int QDepth   = 2;
    localparam int QPtrW    = 1;
    localparam int QCntW    = 2;

    localparam logic       ModePack    = 1'b0;
    localparam logic       ModeUnpack  = 1'b1;

    // Index of the last byte collected or emitted in a group, per mode.
    localparam logic [IdxW-1:0] PackInLast    = 3'd7;
    localparam logic [IdxW-1:0] UnpackInLast  = 3'd6;
    localparam logic [IdxW-1:0] PackOutLast   = 3'd6;
    localparam logic [IdxW-1:0] UnpackOutLast = 3'd7;

    typedef struct packed {
        logic [GroupW-1:0] bits;
        logic              last;
    } t_group;

endpackage

// ===== hdl/spu_front.sv =====
`timescale 1ns / 1ps

module spu_front import spu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  logic             i_clear,
    input  logic             i_accept,
    input  logic [ByteW-1:0] i_in_byte,
    input  logic             i_in_last,
    output logic             o_enq,
    output t_group           o_group
);

    logic [GroupW-1:0] r_bits;
    logic [GroupW-1:0] n_bits;
    logic [IdxW-1:0]   r_count;
    logic [IdxW-1:0]   need_last;
    logic [ShiftW-1:0] shamt;
    logic [GroupW-1:0] field;
    logic              complete;

    always_comb begin
        if (i_mode == ModeUnpack) begin
            need_last = UnpackInLast;
            shamt     = {r_count, 3'b000};
            field     = {{(GroupW-ByteW){1'b0}}, i_in_byte};
        end else begin
            need_last = PackInLast;
            shamt     = {r_count, 3'b000} - {3'b000, r_count};
            field     = {{(GroupW-SeptW){1'b0}}, i_in_byte[SeptW-1:0]};
        end
        n_bits   = r_bits | (field << shamt);
        complete = i_accept && ((r_count == need_last) || i_in_last);
    end

    assign o_enq        = complete;
    assign o_group.bits = n_bits;
    assign o_group.last = i_in_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear || complete) begin
            r_bits  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_bits  <= n_bits;
            r_count <= r_count + 1'b1;
        end
    end

endmodule

// ===== hdl/spu_queue.sv =====
`timescale 1ns / 1ps

module spu_queue import spu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enq,
    input  t_group i_data,
    input  logic   i_deq,
    output t_group o_data,
    output logic   o_valid,
    output logic   o_full
);

    t_group            r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr;
    logic [QPtrW-1:0]  r_rd;
    logic [QCntW-1:0]  r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QCntW'(QDepth));

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_enq && !i_deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_enq && i_deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/spu_back.sv =====
`timescale 1ns / 1ps

module spu_back import spu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mode,
    input  t_group           i_group,
    input  logic             i_valid,
    output logic             o_deq,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_out_last
);

    logic [IdxW-1:0]   r_idx;
    logic              r_out_valid;
    logic [ByteW-1:0]  r_out_byte;
    logic              r_out_last;
    logic [IdxW-1:0]   emit_last;
    logic [ShiftW-1:0] shamt;
    logic [GroupW-1:0] shifted;
    logic [ByteW-1:0]  n_byte;
    logic              load;
    logic              at_end;

    always_comb begin
        if (i_mode == ModeUnpack) begin
            emit_last = UnpackOutLast;
            shamt     = {r_idx, 3'b000} - {3'b000, r_idx};
        end else begin
            emit_last = PackOutLast;
            shamt     = {r_idx, 3'b000};
        end
        shifted = i_group.bits >> shamt;
        if (i_mode == ModeUnpack) begin
            n_byte = {1'b0, shifted[SeptW-1:0]};
        end else begin
            n_byte = shifted[ByteW-1:0];
        end
        load   = i_valid && (!r_out_valid || i_pop);
        at_end = (r_idx == emit_last);
    end

    assign o_deq      = load && at_end;
    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= n_byte;
            r_out_last <= i_group.last && at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/septet_pack_unpack.sv =====
`timescale 1ns / 1ps
// Septet packer and unpacker for byte streams.
// Input channel: a word (i_in_byte, i_in_last) is taken at a clock edge where push is high
// and full is low. In pack mode the low 7 bits of eight words form seven output words; in
// unpack mode seven words expand into eight 7-bit output words with the top bit clear.
// A word with i_in_last set flushes the group, zero-padded, and marks the final output word.
// Output channel: while empty is low the oldest word is on o_out_byte and o_out_last, and
// it is taken at an edge where pop is high.
// The first output word of a group is written into the queue and then into the output
// register before it is shown, when the serializer is free.
// Throughput: input is taken one word per cycle while the two-group queue between the
// collector and the serializer has room; the serializer sends one word per cycle while the
// receiver pops, so in unpack mode, where seven input words give eight, it limits the input.
// A stalled receiver fills the queue and then raises full; nothing is dropped.
// Configuration: i_cfg_we writes the mode (0 pack, 1 unpack) and clears a partial group;
// write only while the block is idle.
// Reset: synchronous, active low; mode returns to pack and the queue and output register are emptied.

module septet_pack_unpack import spu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [ByteW-1:0] i_in_byte,
    input  logic             i_in_last,
    output logic             empty,
    input  logic             pop,
    output logic [ByteW-1:0] o_out_byte,
    output logic             o_out_last
);

    logic   r_mode;
    logic   accept;
    logic   enq;
    logic   deq;
    logic   q_valid;
    logic   q_full;
    t_group enq_group;
    t_group head_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModePack;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    spu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_mode),
        .i_clear   (i_cfg_we),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_enq     (enq),
        .o_group   (enq_group)
    );

    spu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_data  (enq_group),
        .i_deq   (deq),
        .o_data  (head_group),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    spu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_group    (head_group),
        .i_valid    (q_valid),
        .o_deq      (deq),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule
